FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/uee_pkg.sv
// ----------------------------------------------------------------------------
// uee_pkg
// Types, codes and edge helpers for the unique edge extractor.
// ----------------------------------------------------------------------------
package uee_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VIDX_W + 1;

  localparam logic [VCNT_W-1:0] VCNT_MAX   = VCNT_W'(MAX_VERTICES);
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(MAX_VERTICES);

  localparam logic [1:0] EDGE_FIRST = 2'd0;
  localparam logic [1:0] EDGE_LAST  = 2'd2;

  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [VCNT_W-1:0]       vcnt_t;
  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [1:0] {
    ST_NEW_EDGE = 2'd0,
    ST_REJECT   = 2'd1,
    ST_CLEARED  = 2'd2
  } status_t;

  typedef enum logic {
    CMD_FACE  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EDGE = 2'd1,
    S_FIN  = 2'd2
  } state_t;

  typedef struct packed {
    vidx_t rd_addr;
    logic  wr_en;
    vidx_t wr_row;
    row_t  wr_data;
    logic  clr;
  } map_req_t;

  // Edge order: (c,a), (a,b), (b,c)
  function automatic vidx_t edge_x(logic [1:0] k, vidx_t a, vidx_t b, vidx_t c);
    vidx_t r;
    unique case (k)
      2'd0:    r = c;
      2'd1:    r = a;
      default: r = b;
    endcase
    return r;
  endfunction

  function automatic vidx_t edge_y(logic [1:0] k, vidx_t a, vidx_t b, vidx_t c);
    vidx_t r;
    unique case (k)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic vidx_t pair_lo(vidx_t x, vidx_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic vidx_t pair_hi(vidx_t x, vidx_t y);
    return (x < y) ? y : x;
  endfunction

endpackage

FILE: rtl/unique_edge_extractor.sv
// ----------------------------------------------------------------------------
// unique_edge_extractor
// Reports each undirected edge of a triangle stream the first time it is seen.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_ready   command, vertex_a, vertex_b, vertex_c
// out      out_valid / out_ready link_first, link_second, status, last
// cfg      cfg_valid / cfg_ready cfg_data (vertex_count)
//
// A face takes one map probe per edge, then a final state that releases the
// held last result while the next transfer is taken. Clear and rejected faces
// end after the first edge state. The map reads one row and writes one row a
// cycle. Reset and clear empty the map at once through row valid bits. A
// stalled output holds the sequencer on its next new edge.
// ----------------------------------------------------------------------------
module unique_edge_extractor import uee_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  vidx_t      vertex_a,
  input  vidx_t      vertex_b,
  input  vidx_t      vertex_c,
  output logic       out_valid,
  input  logic       out_ready,
  output vidx_t      link_first,
  output vidx_t      link_second,
  output logic [1:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  vcnt_t      cfg_data
);

  vcnt_t    vertex_count;
  map_req_t map_req;
  row_t     map_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  uee_edge_map u_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_bits (map_row)
  );

  uee_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .vertex_c     (vertex_c),
    .vertex_count (vertex_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .link_first   (link_first),
    .link_second  (link_second),
    .status       (status),
    .last         (last),
    .map_req      (map_req),
    .map_row      (map_row)
  );

endmodule

FILE: rtl/uee_edge_map.sv
// ----------------------------------------------------------------------------
// uee_edge_map
// Seen-pair memory, one row per lower vertex, with row valid bits and a
// forward of the last row written.
// ----------------------------------------------------------------------------
module uee_edge_map import uee_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output row_t     rd_bits
);

  row_t                    mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  vidx_t                   rd_row;
  row_t                    rd_data;
  logic                    fwd_valid;
  vidx_t                   fwd_row;
  row_t                    fwd_data;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
    rd_row  <= req.rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (req.clr) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (req.wr_en) begin
      row_valid[req.wr_row] <= 1'b1;
      fwd_valid             <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      fwd_row  <= req.wr_row;
      fwd_data <= req.wr_data;
    end
  end

  assign rd_bits = (fwd_valid && (fwd_row == rd_row)) ? fwd_data :
                   (row_valid[rd_row] ? rd_data : '0);

endmodule

FILE: rtl/uee_ctrl.sv
// ----------------------------------------------------------------------------
// uee_ctrl
// Face sequencer: probes a face's edges on the edge map one per cycle while not
// stalled, holds one pending result to mark the last, drives output register.
// ----------------------------------------------------------------------------
module uee_ctrl import uee_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  vidx_t       vertex_a,
  input  vidx_t       vertex_b,
  input  vidx_t       vertex_c,
  input  vcnt_t       vertex_count,
  output logic        out_valid,
  input  logic        out_ready,
  output vidx_t       link_first,
  output vidx_t       link_second,
  output logic [1:0]  status,
  output logic        last,
  output map_req_t    map_req,
  input  row_t        map_row
);

  state_t     state, state_next;
  logic [1:0] k, k_next;
  cmd_t       cmd_q;
  vidx_t      a_q, b_q, c_q;

  logic       pend_valid;
  vidx_t      pend_first, pend_second;
  status_t    pend_status;

  vidx_t      ex, ey, erow, ebit, nrow;
  logic [1:0] k_inc;
  vcnt_t      limit;
  logic       is_clear, reject, special, is_new, out_free, edge_stall, fin_done;
  logic       accept;

  logic       push, push_last, pend_load, pend_clear;
  vidx_t      load_first, load_second;
  status_t    load_status;

  assign k_inc    = k + 2'd1;
  assign ex       = edge_x(k, a_q, b_q, c_q);
  assign ey       = edge_y(k, a_q, b_q, c_q);
  assign erow     = pair_lo(ex, ey);
  assign ebit     = pair_hi(ex, ey);
  assign nrow     = pair_lo(edge_x(k_inc, a_q, b_q, c_q), edge_y(k_inc, a_q, b_q, c_q));
  assign limit    = (vertex_count > VCNT_MAX) ? VCNT_MAX : vertex_count;
  assign is_clear = (cmd_q == CMD_CLEAR);
  assign reject   = ({1'b0, a_q} >= limit) || ({1'b0, b_q} >= limit) ||
                    ({1'b0, c_q} >= limit);
  assign special  = (k == EDGE_FIRST) && (is_clear || reject);
  assign is_new   = !map_row[ebit];
  assign out_free = !out_valid || out_ready;
  assign edge_stall = is_new && pend_valid && !out_free;
  assign fin_done = !pend_valid || out_free;
  assign in_ready = (state == S_IDLE) || ((state == S_FIN) && fin_done);
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    k_next     = k;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EDGE;
          k_next     = EDGE_FIRST;
        end
      end
      S_EDGE: begin
        if (special) begin
          state_next = S_FIN;
        end else if (!edge_stall) begin
          if (k == EDGE_LAST) begin
            state_next = S_FIN;
          end else begin
            k_next = k_inc;
          end
        end
      end
      S_FIN: begin
        if (fin_done) begin
          if (accept) begin
            state_next = S_EDGE;
            k_next     = EDGE_FIRST;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    push            = 1'b0;
    push_last       = 1'b0;
    pend_load       = 1'b0;
    pend_clear      = 1'b0;
    load_first      = ex;
    load_second     = ey;
    load_status     = ST_NEW_EDGE;
    map_req.rd_addr = erow;
    map_req.wr_en   = 1'b0;
    map_req.wr_row  = erow;
    map_req.wr_data = map_row | (row_t'(1) << ebit);
    map_req.clr     = 1'b0;
    unique case (state)
      S_IDLE: begin
        map_req.rd_addr = pair_lo(vertex_c, vertex_a);
      end
      S_EDGE: begin
        if (special) begin
          pend_load   = 1'b1;
          load_first  = '0;
          load_second = '0;
          load_status = is_clear ? ST_CLEARED : ST_REJECT;
          map_req.clr = is_clear;
        end else if (!edge_stall) begin
          map_req.rd_addr = nrow;
          if (is_new) begin
            map_req.wr_en = 1'b1;
            push          = pend_valid;
            pend_load     = 1'b1;
          end
        end
      end
      S_FIN: begin
        map_req.rd_addr = pair_lo(vertex_c, vertex_a);
        if (pend_valid && out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          pend_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= EDGE_FIRST;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (pend_clear) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      a_q   <= vertex_a;
      b_q   <= vertex_b;
      c_q   <= vertex_c;
    end
    if (pend_load) begin
      pend_first  <= load_first;
      pend_second <= load_second;
      pend_status <= load_status;
    end
    if (push) begin
      link_first  <= pend_first;
      link_second <= pend_second;
      status      <= pend_status;
      last        <= push_last;
    end
  end

endmodule

FILE: rtl/uee_checker.sv
// ----------------------------------------------------------------------------
// uee_checker
// Port-level checks on the unique edge extractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uee_checker import uee_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input vidx_t      link_first,
  input vidx_t      link_second,
  input logic [1:0] status,
  input logic       last
);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(link_first) && $stable(link_second) && $stable(status) && $stable(last), "result changed while stalled")

  `CHK_IMPLY(a_status_code, out_valid, status == ST_NEW_EDGE || status == ST_REJECT || status == ST_CLEARED, "unknown status code")

  `CHK_IMPLY(a_single_result, out_valid && status != ST_NEW_EDGE, last && link_first == '0 && link_second == '0, "reject or clear result malformed")

  `CHK_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready held across an input transfer")

endmodule

bind unique_edge_extractor uee_checker u_uee_checker (.*);
